// ----- rtl/sts_pkg.sv -----
// Shared types and constants for the sorted table search unit.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POS_W    = 11;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_EXACT = 2'd1,
        MODE_LOWER = 2'd2,
        MODE_UPPER = 2'd3
    } mode_t;

    // One classified item on its way from the front end to the search engine.
    typedef struct packed {
        mode_t              mode;
        logic [IDX_W-1:0]   index;
        logic [DATA_W-1:0]  data;   // entry value for a write, key for a search
        logic [POS_W-1:0]   count;  // saturated entry count at accept time
    } cmd_t;

endpackage

// ----- rtl/sts_front.sv -----
// Front end: holds the entry count register and classifies incoming items.
`timescale 1ns / 1ps

module sts_front #(
    parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sts_pkg::POS_W-1:0]   cfg_data,
    input  logic [sts_pkg::MODE_W-1:0]  mode,
    input  logic [sts_pkg::IDX_W-1:0]   entry_index,
    input  logic [sts_pkg::DATA_W-1:0]  entry_value,
    input  logic [sts_pkg::DATA_W-1:0]  search_key,
    output logic                        push,
    output sts_pkg::cmd_t               push_cmd,
    input  logic                        accept
);
    import sts_pkg::*;

    localparam int unsigned CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAP);

    logic [POS_W-1:0] entry_count_reg;
    logic [POS_W-1:0] eff_count;
    logic [31:0]      index_wide;
    logic             is_write;
    logic             keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    assign eff_count  = (entry_count_reg > CAP_POS) ? CAP_POS : entry_count_reg;
    assign index_wide = 32'(entry_index);
    assign is_write   = (mode_t'(mode) == MODE_WRITE);
    // writes beyond the table are taken and dropped
    assign keep       = !is_write || (index_wide < TABLE_DEPTH);

    assign push = accept && keep;

    always_comb
    begin
        push_cmd.mode  = mode_t'(mode);
        push_cmd.index = entry_index;
        push_cmd.data  = is_write ? entry_value : search_key;
        push_cmd.count = eff_count;
    end

endmodule

// ----- rtl/sts_queue.sv -----
// Short command queue between the front end and the search engine.
`timescale 1ns / 1ps

module sts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sts_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sts_pkg::cmd_t   head_cmd
);
    import sts_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_pop;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/sts_back.sv -----
// Search engine: table memory, halving probe sequencer and result register.
`timescale 1ns / 1ps

module sts_back #(
    parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  sts_pkg::cmd_t               head_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sts_pkg::POS_W-1:0]   position,
    output logic                        found
);
    import sts_pkg::*;

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

    state_t            state_reg;
    mode_t             mode_reg;
    logic [DATA_W-1:0] key_reg;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  left_reg;
    logic [POS_W-1:0]  right_reg;
    logic [POS_W-1:0]  mid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  position_reg;
    logic              found_reg;

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [POS_W-1:0]  mid_next;
    logic [31:0]       rd_wide;
    logic [31:0]       wr_wide;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_we;
    logic              mem_re;
    logic              lt;
    logic              gt;

    assign pop      = (state_reg == S_IDLE) && head_valid;
    assign mid_next = left_reg + ((right_reg - left_reg) >> 1);
    assign rd_wide  = 32'(mid_next);
    assign rd_addr  = rd_wide[ADDR_W-1:0];
    assign wr_wide  = 32'(head_cmd.index);
    assign wr_addr  = wr_wide[ADDR_W-1:0];
    assign mem_we   = pop && (head_cmd.mode == MODE_WRITE);
    assign mem_re   = (state_reg == S_PROBE) && (left_reg < right_reg);
    assign lt       = $signed(rd_data_reg) < $signed(key_reg);
    assign gt       = $signed(rd_data_reg) > $signed(key_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= head_cmd.data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_WRITE;
            key_reg       <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            mid_reg       <= '0;
            pos_reg       <= '0;
            hit_reg       <= 1'b0;
            position_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            // in S_DONE the result register is reloaded below instead
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && (head_cmd.mode != MODE_WRITE))
                    begin
                        mode_reg  <= head_cmd.mode;
                        key_reg   <= head_cmd.data;
                        count_reg <= head_cmd.count;
                        left_reg  <= '0;
                        right_reg <= head_cmd.count;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (left_reg < right_reg)
                    begin
                        mid_reg   <= mid_next;
                        state_reg <= S_CMP;
                    end
                    else if (mode_reg == MODE_EXACT)
                    begin
                        pos_reg   <= count_reg;
                        hit_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pos_reg   <= right_reg;
                        hit_reg   <= right_reg < count_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_CMP:
                begin
                    case (mode_reg)
                        MODE_EXACT:
                        begin
                            if (lt)
                            begin
                                left_reg  <= mid_reg + 1'b1;
                                state_reg <= S_PROBE;
                            end
                            else if (gt)
                            begin
                                right_reg <= mid_reg;
                                state_reg <= S_PROBE;
                            end
                            else
                            begin
                                pos_reg   <= mid_reg;
                                hit_reg   <= 1'b1;
                                state_reg <= S_DONE;
                            end
                        end
                        MODE_LOWER:
                        begin
                            if (lt)
                            begin
                                left_reg <= mid_reg + 1'b1;
                            end
                            else
                            begin
                                right_reg <= mid_reg;
                            end
                            state_reg <= S_PROBE;
                        end
                        default:
                        begin
                            if (!gt)
                            begin
                                left_reg <= mid_reg + 1'b1;
                            end
                            else
                            begin
                                right_reg <= mid_reg;
                            end
                            state_reg <= S_PROBE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        position_reg  <= pos_reg;
                        found_reg     <= hit_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign found     = found_reg;

endmodule

// ----- rtl/sorted_table_search_unit.sv -----
// Top level of the sorted table search unit.
`timescale 1ns / 1ps

// Table of TABLE_DEPTH signed 32-bit words, searched by halving over the first
// entry_count entries (saturated to the depth). A write item (mode 0) stores one
// entry and gives no result; writes beyond the depth are dropped. A search item
// (exact, lower bound, upper bound) gives one result. The front end takes items
// into a two-entry queue; the search engine drains it. The engine stores a write
// as it pops it and stays idle. A search runs probes, each of which reads the table
// memory (registered read) in S_PROBE and then compares and narrows the range in
// S_CMP; setup in S_IDLE and the result hand-off in S_DONE frame the probes.
// The result register lets the engine start the next item while a result waits.
// Write entry_count only while the unit is idle. Reading an entry never written
// gives undefined results.
module sorted_table_search_unit #(
    parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sts_pkg::POS_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sts_pkg::MODE_W-1:0]  mode,
    input  logic [sts_pkg::IDX_W-1:0]   entry_index,
    input  logic [sts_pkg::DATA_W-1:0]  entry_value,
    input  logic [sts_pkg::DATA_W-1:0]  search_key,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sts_pkg::POS_W-1:0]   position,
    output logic                        found
);
    import sts_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  full;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;
    logic  accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .push        (push),
        .push_cmd    (push_cmd),
        .accept      (accept)
    );

    sts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .found      (found)
    );

endmodule
